>>> rtl/tlvs_pkg.sv
// Shared types and constants of the variable-step Tustin low-pass filter.
`default_nettype none
package tlvs_pkg;

    typedef logic [3:0] t_op;

    localparam t_op OP_NONE   = 4'd0;
    localparam t_op OP_LOAD   = 4'd1;
    localparam t_op OP_GAIN   = 4'd2;
    localparam t_op OP_KSET   = 4'd3;
    localparam t_op OP_MUL1   = 4'd4;
    localparam t_op OP_MUL2   = 4'd5;
    localparam t_op OP_NUM    = 4'd6;
    localparam t_op OP_DINIT  = 4'd7;
    localparam t_op OP_DSTEP  = 4'd8;
    localparam t_op OP_FINISH = 4'd9;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic restart;
        logic out_free;
    } t_sts;

    localparam logic [23:0] CUTOFF_RESET = 24'd117440;
    localparam logic [55:0] GAIN_LIMIT   = 56'd4278190080;
    localparam logic [27:0] K_MAX        = 28'hFF0_0000;
    localparam logic [29:0] K_TWO        = 30'h0020_0000;

    localparam int DIV_STEPS = 41;
    localparam int CNT_W     = $clog2(DIV_STEPS);

endpackage
`default_nettype wire

>>> rtl/tlvs_ctrl.sv
// Sequencer that steps the filter datapath through one request.
`default_nettype none
module tlvs_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_stall,
    input  wire tlvs_pkg::t_sts  i_sts,
    output tlvs_pkg::t_cmd       o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_GAIN  = 4'd1;
    localparam logic [3:0] S_K     = 4'd2;
    localparam logic [3:0] S_MUL1  = 4'd3;
    localparam logic [3:0] S_MUL2  = 4'd4;
    localparam logic [3:0] S_NUM   = 4'd5;
    localparam logic [3:0] S_DINIT = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    localparam logic [tlvs_pkg::CNT_W-1:0] CNT_LAST =
        tlvs_pkg::CNT_W'(tlvs_pkg::DIV_STEPS - 1);

    logic [3:0]                 r_state, n_state;
    logic [tlvs_pkg::CNT_W-1:0] r_cnt, n_cnt;

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd.op   = tlvs_pkg::OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.op = tlvs_pkg::OP_LOAD;
                    n_state  = S_GAIN;
                end
            end
            S_GAIN: begin
                if (i_sts.restart) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.op = tlvs_pkg::OP_GAIN;
                    n_state  = S_K;
                end
            end
            S_K: begin
                o_cmd.op = tlvs_pkg::OP_KSET;
                n_state  = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.op = tlvs_pkg::OP_MUL1;
                n_state  = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.op = tlvs_pkg::OP_MUL2;
                n_state  = S_NUM;
            end
            S_NUM: begin
                o_cmd.op = tlvs_pkg::OP_NUM;
                n_state  = S_DINIT;
            end
            S_DINIT: begin
                o_cmd.op = tlvs_pkg::OP_DINIT;
                n_cnt    = '0;
                n_state  = S_DIV;
            end
            S_DIV: begin
                o_cmd.op = tlvs_pkg::OP_DSTEP;
                if (r_cnt == CNT_LAST) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.op = tlvs_pkg::OP_FINISH;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule
`default_nettype wire

>>> rtl/tlvs_dp.sv
// Datapath of the filter: history, shared multiplier, divider and output register.
`default_nettype none
module tlvs_dp (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire tlvs_pkg::t_cmd     i_cmd,
    output tlvs_pkg::t_sts          o_sts,
    input  wire logic               i_cfg_we,
    input  wire logic [23:0]        i_cfg_wdata,
    input  wire logic signed [31:0] i_sample,
    input  wire logic [31:0]        i_timestamp,
    input  wire logic               i_restart,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [31:0]      o_filtered,
    output logic                    o_saturated
);

    logic [23:0]        r_cutoff;
    logic [31:0]        r_tp;
    logic [31:0]        r_xp;
    logic [31:0]        r_yp;
    logic [31:0]        r_x;
    logic [31:0]        r_t;
    logic               r_restart;
    logic signed [63:0] r_mul;
    logic signed [63:0] r_p1;
    logic signed [63:0] r_num;
    logic [27:0]        r_k;
    logic               r_ksat;
    logic [28:0]        r_rem;
    logic [40:0]        r_quo;
    logic               r_neg;
    logic               r_out_valid;
    logic [31:0]        r_out;
    logic               r_out_sat;

    logic [31:0]        dt;
    logic [32:0]        xsum;
    logic signed [33:0] mul_a;
    logic signed [29:0] mul_b;
    logic signed [63:0] mul_p;
    logic [55:0]        prod;
    logic [28:0]        den;
    logic [63:0]        dividend;
    logic [29:0]        trial;
    logic               ge;
    logic [29:0]        trial_sub;
    logic [31:0]        y;
    logic               y_sat;

    assign dt   = r_t - r_tp;
    assign xsum = {r_x[31], r_x} + {r_xp[31], r_xp};

    always_comb begin
        unique case (i_cmd.op)
            tlvs_pkg::OP_GAIN: begin
                mul_a = $signed({2'b00, dt});
                mul_b = $signed({6'b000000, r_cutoff});
            end
            tlvs_pkg::OP_MUL1: begin
                mul_a = $signed({xsum[32], xsum});
                mul_b = $signed({2'b00, r_k});
            end
            tlvs_pkg::OP_MUL2: begin
                mul_a = $signed({{2{r_yp[31]}}, r_yp});
                mul_b = $signed(tlvs_pkg::K_TWO - {2'b00, r_k});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;
    assign prod  = r_mul[55:0];
    assign den   = {1'b0, r_k} + tlvs_pkg::K_TWO[28:0];

    // The magnitude and the rounding half are formed in one add.
    assign dividend = (r_num[63] ? ~r_num : r_num) + {36'd0, den[28:1]} + {63'd0, r_num[63]};

    assign trial     = {r_rem, r_quo[40]};
    assign ge        = (trial >= {1'b0, den});
    assign trial_sub = trial - {1'b0, den};

    always_comb begin
        y     = r_quo[31:0];
        y_sat = 1'b0;
        if (r_restart) begin
            y = r_x;
        end else if (r_neg) begin
            if (r_quo > 41'h0_8000_0000) begin
                y     = 32'h8000_0000;
                y_sat = 1'b1;
            end else begin
                y = ~r_quo[31:0] + 32'd1;
            end
        end else if (r_quo > 41'h0_7FFF_FFFF) begin
            y     = 32'h7FFF_FFFF;
            y_sat = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            tlvs_pkg::OP_LOAD: begin
                r_x       <= i_sample;
                r_t       <= i_timestamp;
                r_restart <= i_restart;
            end
            tlvs_pkg::OP_GAIN: begin
                r_mul <= mul_p;
            end
            tlvs_pkg::OP_KSET: begin
                if (prod > tlvs_pkg::GAIN_LIMIT) begin
                    r_k    <= tlvs_pkg::K_MAX;
                    r_ksat <= 1'b1;
                end else begin
                    r_k    <= prod[31:4];
                    r_ksat <= 1'b0;
                end
            end
            tlvs_pkg::OP_MUL1: begin
                r_mul <= mul_p;
            end
            tlvs_pkg::OP_MUL2: begin
                r_p1  <= r_mul;
                r_mul <= mul_p;
            end
            tlvs_pkg::OP_NUM: begin
                r_num <= r_p1 + r_mul;
            end
            tlvs_pkg::OP_DINIT: begin
                r_neg <= r_num[63];
                r_rem <= {8'd0, dividend[61:41]};
                r_quo <= dividend[40:0];
            end
            tlvs_pkg::OP_DSTEP: begin
                r_rem <= ge ? trial_sub[28:0] : trial[28:0];
                r_quo <= {r_quo[39:0], ge};
            end
            tlvs_pkg::OP_FINISH: begin
                r_out     <= y;
                r_out_sat <= y_sat | (r_ksat & ~r_restart);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cutoff    <= tlvs_pkg::CUTOFF_RESET;
            r_tp        <= '0;
            r_xp        <= '0;
            r_yp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cutoff <= i_cfg_wdata;
            end
            if (i_cmd.op == tlvs_pkg::OP_FINISH) begin
                r_tp        <= r_t;
                r_xp        <= r_x;
                r_yp        <= y;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.restart  = r_restart;
    assign o_sts.out_free = !r_out_valid || !i_stall;
    assign o_valid        = r_out_valid;
    assign o_filtered     = r_out;
    assign o_saturated    = r_out_sat;

endmodule
`default_nettype wire

>>> rtl/tustin_lowpass_variable_step_top.sv
// Top level of the variable-step Tustin low-pass filter.
//
//   channel   direction  handshake           payload
//   input     in         i_valid / o_stall   i_sample, i_timestamp, i_restart
//   result    out        o_valid / i_stall   o_filtered, o_saturated
//   config    in         i_cfg_we            i_cfg_wdata
//
// A filtering request steps through the gain, K, multiply, numerator and
// divider-init states, then the one-bit-per-cycle restoring divider, before the
// next request is accepted. A restart request skips from gain straight to done.
// Reset is synchronous and active low; it restores the cutoff and clears the history.
// A result that waits in the output register does not block the next request; only
// the end of the following one waits for it.
`default_nettype none
module tustin_lowpass_variable_step_top (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [23:0]        i_cfg_wdata,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic signed [31:0] i_sample,
    input  wire logic [31:0]        i_timestamp,
    input  wire logic               i_restart,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [31:0]      o_filtered,
    output logic                    o_saturated
);

    tlvs_pkg::t_cmd cmd;
    tlvs_pkg::t_sts sts;

    tlvs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    tlvs_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_sample    (i_sample),
        .i_timestamp (i_timestamp),
        .i_restart   (i_restart),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_filtered  (o_filtered),
        .o_saturated (o_saturated)
    );

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input not stalled after a request was accepted");

    a_finish_shows_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.op == tlvs_pkg::OP_FINISH) |=> o_valid)
        else $error("finished request did not reach the output register");

    a_finish_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.op == tlvs_pkg::OP_FINISH) |-> (!o_valid || !i_stall))
        else $error("output register overwritten while its result was stalled");

    a_restart_not_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.op == tlvs_pkg::OP_FINISH && sts.restart) |=> !o_saturated)
        else $error("restart request reported saturation");
`endif

endmodule
`default_nettype wire

>>> verif/tb.sv
// Self-checking testbench for the variable-step Tustin low-pass filter.
`timescale 1ns / 100ps
module tb;

    localparam int       REQ_CYCLES  = 49;
    localparam int       SETTLE      = 2 * REQ_CYCLES + 20;
    localparam int       DRAIN_LIMIT = 50000;
    localparam int       HOLD_CYCLES = 400;
    localparam int       PHASES      = 9;
    localparam int       PHASE_ITEMS = 220;
    localparam longint   K_TWO_Q20   = 64'sd2 << 20;
    localparam longint unsigned K_CLIP_Q20   = 64'd255 << 20;
    localparam longint unsigned GAIN_CLIP_Q24 = 64'd255 << 24;
    localparam logic [23:0] CUTOFF_AT_RESET = 24'd117440;

    typedef struct {
        logic signed [31:0] filtered;
        logic               saturated;
    } t_filter_out;

    class filter_scoreboard;
        logic [23:0]        cutoff;
        logic [31:0]        last_time;
        logic signed [31:0] last_sample;
        logic signed [31:0] last_output;
        t_filter_out        expected_outputs[$];
        int                 mismatches;
        int                 checked;
        int                 restarts;
        int                 gain_clips;
        int                 output_clips;

        function new();
            cutoff       = CUTOFF_AT_RESET;
            last_time    = '0;
            last_sample  = '0;
            last_output  = '0;
            mismatches   = 0;
            checked      = 0;
            restarts     = 0;
            gain_clips   = 0;
            output_clips = 0;
        endfunction

        function void set_cutoff(logic [23:0] value);
            cutoff = value;
        endfunction

        function int pending();
            return expected_outputs.size();
        endfunction

        function void note_request(logic signed [31:0] x, logic [31:0] ts, logic restart);
            t_filter_out        exp_out;
            logic [31:0]        dt;
            longint unsigned    prod;
            longint unsigned    k;
            longint unsigned    den;
            longint unsigned    mag;
            longint unsigned    q;
            longint             num;
            logic signed [31:0] y;
            logic               sat;
            if (restart) begin
                last_sample = x;
                last_output = x;
                last_time   = ts;
                restarts++;
                exp_out.filtered  = x;
                exp_out.saturated = 1'b0;
                expected_outputs.insert(expected_outputs.size(), exp_out);
                return;
            end
            sat  = 1'b0;
            dt   = ts - last_time;
            prod = {32'd0, dt} * {40'd0, cutoff};
            if (prod > GAIN_CLIP_Q24) begin
                k   = K_CLIP_Q20;
                sat = 1'b1;
                gain_clips++;
            end else begin
                k = prod >> 4;
            end
            num = (longint'(x) + longint'(last_sample)) * longint'(k)
                + longint'(last_output) * (K_TWO_Q20 - longint'(k));
            den = K_TWO_Q20 + k;
            mag = (num < 0) ? -num : num;
            q   = (mag + (den >> 1)) / den;
            if (num < 0) begin
                if (q > 64'h8000_0000) begin
                    y   = 32'sh8000_0000;
                    sat = 1'b1;
                    output_clips++;
                end else begin
                    y = 32'(64'd0 - q);
                end
            end else begin
                if (q > 64'h7FFF_FFFF) begin
                    y   = 32'sh7FFF_FFFF;
                    sat = 1'b1;
                    output_clips++;
                end else begin
                    y = q[31:0];
                end
            end
            last_time   = ts;
            last_sample = x;
            last_output = y;
            exp_out.filtered  = y;
            exp_out.saturated = sat;
            expected_outputs.insert(expected_outputs.size(), exp_out);
        endfunction

        function void check_result(logic signed [31:0] filtered, logic saturated);
            t_filter_out exp_out;
            if (expected_outputs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: filtered %0d saturated %0b",
                             filtered, saturated);
                return;
            end
            exp_out = expected_outputs.pop_front();
            checked++;
            if (filtered !== exp_out.filtered || saturated !== exp_out.saturated) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch on result %0d: expected %0d/%0b, got %0d/%0b",
                             checked, exp_out.filtered, exp_out.saturated,
                             filtered, saturated);
            end
        endfunction
    endclass

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_cfg_we    = 1'b0;
    logic [23:0]        i_cfg_wdata = '0;
    logic               i_valid     = 1'b0;
    logic               o_stall;
    logic signed [31:0] i_sample    = '0;
    logic [31:0]        i_timestamp = '0;
    logic               i_restart   = 1'b0;
    logic               o_valid;
    logic               i_stall     = 1'b0;
    logic signed [31:0] o_filtered;
    logic               o_saturated;

    filter_scoreboard sb;
    int               send_idle_pct = 38;
    int               recv_idle_pct = 56;
    bit               hold_off_req  = 1'b0;
    logic [23:0]      cutoff_now    = CUTOFF_AT_RESET;
    logic [31:0]      cur_time      = '0;
    int               requests_sent = 0;
    int               cutoff_writes = 0;

    tustin_lowpass_variable_step_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_sample    (i_sample),
        .i_timestamp (i_timestamp),
        .i_restart   (i_restart),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_filtered  (o_filtered),
        .o_saturated (o_saturated)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_filtered, o_saturated);
    end

    task automatic drive_request(logic signed [31:0] x, logic [31:0] ts, logic restart);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_sample    <= x;
        i_timestamp <= ts;
        i_restart   <= restart;
        do @(posedge i_clk); while (o_stall);
        sb.note_request(x, ts, restart);
        cur_time = ts;
        requests_sent++;
    endtask

    task automatic drain_requests();
        int waited;
        waited = 0;
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_cutoff(logic [23:0] value);
        drain_requests();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        sb.set_cutoff(value);
        cutoff_now = value;
        cutoff_writes++;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic signed [31:0] pick_sample();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 50)
            return $urandom;
        else if (sel < 80)
            return $signed($urandom_range(0, 32'h0007_FFFF)) - 32'sh0004_0000;
        else if (sel < 90)
            return 32'sh7FFF_FFFF;
        else
            return 32'sh8000_0000;
    endfunction

    task automatic run_random(int count);
        longint unsigned lim;
        logic [31:0]     dt_span;
        logic [31:0]     ts;
        int              sel;
        lim = (cutoff_now == 0) ? 64'hFFFF_FFFF : GAIN_CLIP_Q24 / cutoff_now;
        if (lim > 64'hFFFF_FFFF)
            lim = 64'hFFFF_FFFF;
        dt_span = lim[31:0];
        repeat (count) begin
            sel = $urandom_range(0, 99);
            if (sel < 10) begin
                ts = ($urandom_range(0, 3) == 0) ? $urandom : cur_time + $urandom_range(0, 1000);
                drive_request(pick_sample(), ts, 1'b1);
            end else begin
                sel = $urandom_range(0, 99);
                if (sel < 55)
                    ts = cur_time + $urandom_range(0, dt_span);
                else if (sel < 70)
                    ts = cur_time + dt_span + $urandom_range(0, 2) - 1;
                else if (sel < 80)
                    ts = cur_time;
                else if (sel < 90)
                    ts = cur_time + $urandom_range(0, 7);
                else
                    ts = $urandom;
                drive_request(pick_sample(), ts, 1'b0);
            end
        end
    endtask

    initial begin
        logic [23:0] phase_cutoff[PHASES];
        sb = new();
        phase_cutoff = '{24'd0, 24'hFF_FFFF, CUTOFF_AT_RESET, 24'd1, 24'($urandom),
                         24'd2000, 24'($urandom), 24'h80_0000, 24'($urandom)};
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // History is still zero here, so the first request filters against zeros.
        drive_request(32'sh0001_0000, 32'd1000, 1'b0);
        drive_request(32'sh0001_0000, 32'd1000, 1'b0);
        drive_request(32'sh0002_0000, 32'd37428, 1'b0);
        drive_request(32'sh0003_0000, 32'd73857, 1'b0);
        drive_request(32'sh7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        drive_request(32'sh1234_5678, 32'hFFFF_FF00, 1'b0);
        drive_request(32'sh8000_0000, 32'd100, 1'b1);
        drive_request(32'sh7FFF_FFFF, 32'd100, 1'b0);
        drive_request(32'sh7FFF_FFFF, 32'd100100, 1'b0);
        drive_request(32'sh8000_0000, 32'd100200, 1'b0);
        drive_request(32'sh7FFF_FFFF, 32'd500, 1'b1);
        drive_request(32'sh8000_0000, 32'd500, 1'b0);
        drive_request(32'sh8000_0000, 32'd100500, 1'b0);
        drive_request(32'sh0000_0000, 32'd0, 1'b1);
        drive_request(32'shFFFF_FFFF, 32'd1, 1'b0);
        drive_request(32'sh5555_5555, 32'hAAAA_AAAA, 1'b0);
        drive_request(32'shAAAA_AAAA, 32'h5555_5555, 1'b1);
        drive_request(32'sh0000_8000, 32'h5555_6555, 1'b0);

        for (int p = 0; p < PHASES; p++) begin
            if (p == 3) begin
                send_idle_pct = 56;
                recv_idle_pct = 38;
            end else if (p == 6) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_cutoff(phase_cutoff[p]);
            if (p == 6)
                hold_off_req = 1'b1;
            run_random(PHASE_ITEMS / 2);
            if (p == 4)
                drain_requests();
            run_random(PHASE_ITEMS - PHASE_ITEMS / 2);
        end
        drain_requests();

        $display("Sent %0d requests (%0d restarts) over %0d cutoff writes; %0d results checked.",
                 requests_sent, sb.restarts, cutoff_writes, sb.checked);
        $display("Gain clipped %0d times, output clipped %0d times, %0d mismatches, %0d left over.",
                 sb.gain_clips, sb.output_clips, sb.mismatches, sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Timeout after %0d requests, %0d results still expected.",
                 requests_sent, sb.pending());
        $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> filelist.f
rtl/tlvs_pkg.sv
rtl/tlvs_ctrl.sv
rtl/tlvs_dp.sv
rtl/tustin_lowpass_variable_step_top.sv
verif/tb.sv
